// ----- src/sorted_list_engine_unit_defines.svh -----
// Assertion macros for the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_ENGINE_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/sle_pkg.sv -----
// Shared constants and types of the sorted list engine.
package sle_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // operation codes
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_ITER   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_END       = 3'd5;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_POP
  } cell_cmd_e;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  // per-cell compare flags, already qualified by the cell's valid bit
  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ----- src/sle_cell.sv -----
// One slot of the sorted list: holds a key and shifts with its neighbors.
module sle_cell (
  input  logic                     clk_i,
  input  sle_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     valid_i,
  input  logic                     at_end_i,
  input  logic                     sel_i,
  input  logic                     left_gt_i,
  input  logic [sle_pkg::KEY_W-1:0] left_key_i,
  input  logic [sle_pkg::KEY_W-1:0] right_key_i,
  output logic [sle_pkg::KEY_W-1:0] key_o,
  output sle_pkg::cell_flags_t     flags_o,
  output logic [sle_pkg::KEY_W-1:0] rd_o
);
  import sle_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;

  assign key_o      = key_q;
  assign flags_o.gt = valid_i && (key_q > ctrl_i.key);
  assign flags_o.lt = valid_i && (key_q < ctrl_i.key);
  assign flags_o.eq = valid_i && (key_q == ctrl_i.key);
  assign rd_o       = sel_i ? key_q : '0;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.cmd)
      CMD_INS: begin
        // larger keys move right; the slot at the boundary takes the new key
        if (left_gt_i) begin
          key_d = left_key_i;
        end else if (flags_o.gt || at_end_i) begin
          key_d = ctrl_i.key;
        end
      end
      CMD_DEL: begin
        // everything from the first equal key onward moves left
        if (!flags_o.lt) begin
          key_d = right_key_i;
        end
      end
      CMD_POP: key_d = right_key_i;
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ----- src/sorted_list_engine_unit.sv -----
// Top level of the sorted list engine: command port, control and the row of cells.
//
//  channel   direction  handshake              payload
//  command   in         start && !busy         mode_i, key_i, index_i
//  result    out        done_o (one cycle)     status_o, value_o, count_o,
//                                              last_value_o, last_valid_o
//
// Each transaction runs as follows: the accept edge latches the command,
// and in the following cycle (busy high) all cells compare against the key
// and shift in parallel while the result is registered. done_o rises the
// cycle after that, and a new command may be accepted in that same cycle.
// No new command is accepted while busy is high, so only one transaction is
// in flight at a time. Reset clears count, cursor and last-key valid; cell
// contents stay undefined until written. The receiver has no back pressure.
module sorted_list_engine_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                mode_i,
  input  logic [sle_pkg::KEY_W-1:0] key_i,
  input  logic [3:0]                index_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [sle_pkg::KEY_W-1:0] value_o,
  output logic [sle_pkg::CNT_W-1:0] count_o,
  output logic [sle_pkg::KEY_W-1:0] last_value_o,
  output logic                      last_valid_o
);
  import sle_pkg::*;

  `include "sorted_list_engine_unit_defines.svh"

  // latched command
  logic             pend_q;
  logic [2:0]       mode_q;
  logic [KEY_W-1:0] key_q;
  logic [3:0]       index_q;

  // list state
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic             ended_q, ended_d;
  logic [KEY_W-1:0] last_key_q, last_key_d;
  logic             last_vld_q, last_vld_d;

  // result registers
  logic             done_q;
  logic [2:0]       status_q, status_d;
  logic [KEY_W-1:0] value_q, value_d;

  // cell row
  cell_ctrl_t       ctrl;
  cell_cmd_e        cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [KEY_W-1:0] cell_rd  [DEPTH];
  cell_flags_t      cell_flags [DEPTH];
  logic [DEPTH-1:0] gt_v, lt_v, eq_v, cur_oh;
  logic [KEY_W-1:0] rd_val;

  logic             accept;
  logic             found;
  logic             lt_prev;
  logic             eq_cur;
  logic [CNT_W-1:0] cursor_ext;
  logic [CNT_W-1:0] cursor_nxt;

  assign accept = start && !busy;
  assign busy   = pend_q;

  assign ctrl.cmd = cmd;
  assign ctrl.key = key_q;

  // pop reads the head, read uses the index, iterate uses the cursor
  always_comb begin
    if (mode_q == MODE_READ) begin
      rd_addr = index_q[IDX_W-1:0];
    end else if (mode_q == MODE_POP) begin
      rd_addr = '0;
    end else begin
      rd_addr = cursor_q;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             vld;
    logic             at_end;
    logic             lgt;
    logic [KEY_W-1:0] lkey;
    logic [KEY_W-1:0] rkey;

    assign vld    = CNT_W'(i) < count_q;
    assign at_end = CNT_W'(i) == count_q;

    if (i == 0) begin : g_first
      assign lgt  = 1'b0;
      assign lkey = '0;
    end else begin : g_mid
      assign lgt  = gt_v[i-1];
      assign lkey = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = '0;
    end else begin : g_body
      assign rkey = cell_key[i+1];
    end

    sle_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (vld),
      .at_end_i    (at_end),
      .sel_i       (rd_addr == IDX_W'(i)),
      .left_gt_i   (lgt),
      .left_key_i  (lkey),
      .right_key_i (rkey),
      .key_o       (cell_key[i]),
      .flags_o     (cell_flags[i]),
      .rd_o        (cell_rd[i])
    );

    assign gt_v[i]   = cell_flags[i].gt;
    assign lt_v[i]   = cell_flags[i].lt;
    assign eq_v[i]   = cell_flags[i].eq;
    assign cur_oh[i] = vld && (cursor_q == IDX_W'(i));
  end

  // OR of the selected slot; unselected slots drive zero
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

  // List is sorted, so the first equal key sits before the cursor exactly
  // when the slot left of the cursor is not below the key.
  assign found      = |eq_v;
  assign lt_prev    = |((lt_v << 1) & cur_oh);
  assign eq_cur     = |(eq_v & cur_oh);
  assign cursor_ext = CNT_W'(cursor_q);
  assign cursor_nxt = cursor_ext + CNT_W'(1);

  always_comb begin
    cmd        = CMD_HOLD;
    status_d   = ST_OK;
    value_d    = '0;
    count_d    = count_q;
    cursor_d   = cursor_q;
    ended_d    = ended_q;
    last_key_d = last_key_q;
    last_vld_d = last_vld_q;

    case (mode_q)
      MODE_INSERT: begin
        if (count_q == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          cmd        = CMD_INS;
          count_d    = count_q + CNT_W'(1);
          last_key_d = key_q;
          last_vld_d = 1'b1;
          cursor_d   = '0;
          ended_d    = 1'b0;
        end
      end
      MODE_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cmd        = CMD_POP;
          value_d    = rd_val;
          count_d    = count_q - CNT_W'(1);
          last_vld_d = 1'b0;
          cursor_d   = '0;
          ended_d    = 1'b0;
        end
      end
      MODE_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          // covers keys outside the stored range as well
          status_d = ST_NOT_FOUND;
        end else begin
          cmd        = CMD_DEL;
          count_d    = count_q - CNT_W'(1);
          last_vld_d = 1'b0;
          if (eq_v[0]) begin
            // removing the head behaves like a pop
            cursor_d = '0;
            ended_d  = 1'b0;
          end else if (!ended_q) begin
            if (cursor_q != '0 && !lt_prev) begin
              cursor_d = cursor_q - IDX_W'(1);
            end else if (eq_cur && (cursor_q == '0 || lt_prev) &&
                         cursor_nxt >= count_q) begin
              cursor_d = '0;
              ended_d  = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        if (CNT_W'(index_q) >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          value_d = rd_val;
        end
      end
      MODE_ITER: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (ended_q || cursor_ext >= count_q) begin
          status_d = ST_END;
          cursor_d = '0;
          ended_d  = 1'b0;
        end else begin
          value_d = rd_val;
          if (cursor_nxt >= count_q) begin
            cursor_d = '0;
            ended_d  = 1'b1;
          end else begin
            cursor_d = cursor_q + IDX_W'(1);
          end
        end
      end
      default: ;  // unused modes: no change, status ok
    endcase

    if (!pend_q) begin
      cmd = CMD_HOLD;
    end
  end

  // command latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      index_q <= index_i;
    end
  end

  // list control state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      cursor_q   <= '0;
      ended_q    <= 1'b1;
      last_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= pend_q;
      if (pend_q) begin
        count_q    <= count_d;
        cursor_q   <= cursor_d;
        ended_q    <= ended_d;
        last_vld_q <= last_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      last_key_q <= last_key_d;
      status_q   <= status_d;
      value_q    <= value_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign value_o      = value_q;
  assign count_o      = count_q;
  assign last_valid_o = last_vld_q;
  assign last_value_o = last_vld_q ? last_key_q : '0;

  // a result never coincides with an operation in flight
  `SLE_ASSERT(a_done_not_busy, !(done_o && busy), "result strobe while busy")
  // every executed operation yields exactly one result next cycle
  `SLE_ASSERT(a_busy_done, busy |=> done_o, "operation produced no result")
  // full is reported only at capacity
  `SLE_ASSERT(a_full_cnt, (done_o && status_o == ST_FULL) |-> (count_o == CNT_W'(DEPTH)),
              "full status below capacity")
  // count never exceeds capacity
  `SLE_ASSERT(a_cnt_max, count_q <= CNT_W'(DEPTH), "count above capacity")

endmodule

// ----- bench/sorted_list_engine_unit_test.sv -----
// Self-checking testbench for the sorted list engine: directed and random command traffic.
module sorted_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  // Mode codes that the block treats as no-ops.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 800;
  // Roughly 830 transactions plus gaps and drains; kept far above what they need.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Quiet cycles watched at the end for stray results.
  localparam int unsigned TAIL_CYCLES  = 10;

  typedef struct {
    logic [2:0]       status;
    logic [KEY_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] last_value;
    logic             last_valid;
  } list_result_t;

  // Mirror of the sorted list: holds the keys, the cursor and the
  // last-inserted key, and queues the result each accepted command implies.
  class sorted_list_mirror;
    logic [KEY_W-1:0] keys[DEPTH];
    int               fill;
    int               cursor;
    bit               ended;
    logic [KEY_W-1:0] last_key;
    bit               last_ok;
    list_result_t     pending_results[$];
    int unsigned      fail_count;

    function new();
      fill       = 0;
      cursor     = 0;
      ended      = 1'b1;
      last_key   = '0;
      last_ok    = 1'b0;
      fail_count = 0;
    endfunction

    function void rewind();
      cursor = 0;
      ended  = 1'b0;
    endfunction

    // Close the gap left by the key at pos; drops the last-key flag.
    function void take_out(int pos);
      for (int i = pos; i + 1 < fill; i++) keys[i] = keys[i + 1];
      fill--;
      last_ok = 1'b0;
    endfunction

    function void record_command(logic [2:0] mode, logic [KEY_W-1:0] key, logic [3:0] idx);
      list_result_t res;
      int           pos;
      res.status = ST_OK;
      res.value  = '0;
      case (mode)
        MODE_INSERT: begin
          if (fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            // after any equal keys
            pos = 0;
            while (pos < fill && keys[pos] <= key) pos++;
            for (int i = fill; i > pos; i--) keys[i] = keys[i - 1];
            keys[pos] = key;
            fill++;
            last_key = key;
            last_ok  = 1'b1;
            rewind();
          end
        end
        MODE_POP: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.value = keys[0];
            take_out(0);
            rewind();
          end
        end
        MODE_REMOVE: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (key < keys[0] || key > keys[fill - 1]) begin
            res.status = ST_NOT_FOUND;
          end else begin
            pos = 0;
            while (pos < fill && keys[pos] != key) pos++;
            if (pos >= fill) begin
              res.status = ST_NOT_FOUND;
            end else if (pos == 0) begin
              take_out(0);
              rewind();
            end else begin
              if (!ended) begin
                if (pos < cursor) begin
                  cursor--;
                end else if (pos == cursor && pos + 1 >= fill) begin
                  cursor = 0;
                  ended  = 1'b1;
                end
              end
              take_out(pos);
            end
          end
        end
        MODE_READ: begin
          if (idx >= fill) res.status = ST_RANGE;
          else             res.value  = keys[idx];
        end
        MODE_ITER: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (ended || cursor >= fill) begin
            res.status = ST_END;
            rewind();
          end else begin
            res.value = keys[cursor];
            if (cursor + 1 >= fill) begin
              cursor = 0;
              ended  = 1'b1;
            end else begin
              cursor++;
            end
          end
        end
        default: ;
      endcase
      res.count      = fill[CNT_W-1:0];
      res.last_valid = last_ok;
      res.last_value = last_ok ? last_key : '0;
      pending_results.push_back(res);
    endfunction

    function void compare_result(list_result_t got);
      list_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with none pending: status %0d value %h count %0d",
               got.status, got.value, got.count);
        fail_count++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
        fail_count++;
      end
      if (got.value !== exp.value) begin
        $error("value mismatch: expected %h, actual %h", exp.value, got.value);
        fail_count++;
      end
      if (got.count !== exp.count) begin
        $error("count mismatch: expected %0d, actual %0d", exp.count, got.count);
        fail_count++;
      end
      if (got.last_value !== exp.last_value) begin
        $error("last_value mismatch: expected %h, actual %h", exp.last_value, got.last_value);
        fail_count++;
      end
      if (got.last_valid !== exp.last_valid) begin
        $error("last_valid mismatch: expected %0d, actual %0d", exp.last_valid, got.last_valid);
        fail_count++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [2:0]       mode_i;
  logic [KEY_W-1:0] key_i;
  logic [3:0]       index_i;
  logic             done_o;
  logic [2:0]       status_o;
  logic [KEY_W-1:0] value_o;
  logic [CNT_W-1:0] count_o;
  logic [KEY_W-1:0] last_value_o;
  logic             last_valid_o;

  sorted_list_mirror mirror = new();
  int unsigned       burst_left;
  int unsigned       cycle_count;

  sorted_list_engine_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .index_i      (index_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .value_o      (value_o),
    .count_o      (count_o),
    .last_value_o (last_value_o),
    .last_valid_o (last_valid_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL sorted_list_engine_unit");
      $finish;
    end
  end

  // Result monitor. done_o is a one-cycle strobe with no back pressure, so
  // every edge where it was high carries one transaction. Values read right
  // after the edge are the pre-edge ones.
  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && done_o === 1'b1) begin
      got.status     = status_o;
      got.value      = value_o;
      got.count      = count_o;
      got.last_value = last_value_o;
      got.last_valid = last_valid_o;
      mirror.compare_result(got);
    end
  end

  // Bursts are mostly short, sometimes long stretches with start held high.
  function automatic int unsigned next_burst();
    if ($urandom_range(0, 4) == 0) return $urandom_range(30, 60);
    return $urandom_range(1, 12);
  endfunction

  // Drive one command and hold it until the block takes it. Once the burst
  // runs out, start drops for a random gap; odd gap lengths shift later
  // commands onto the other phase of the accept-and-execute step.
  task automatic issue(input logic [2:0] m, input logic [KEY_W-1:0] k, input logic [3:0] ix);
    start   <= 1'b1;
    mode_i  <= m;
    key_i   <= k;
    index_i <= ix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mirror.record_command(m, k, ix);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = next_burst();
    end
  endtask

  // Hold off until every outstanding transaction has reported. The loop waits
  // on the clock before it checks, so start never gets two assignments in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (mirror.pending_results.size() != 0);
  endtask

  // Keys: most often ones already stored or their neighbors (hits and near misses
  // for remove), then a small cluster at each end of the range, then anything.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int unsigned      sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3 && mirror.fill > 0) begin
      k = mirror.keys[$urandom_range(0, mirror.fill - 1)];
      if (sel == 3) k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
    end else if (sel <= 6) begin
      k = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 7))
                               : {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 7));
    end else begin
      k = KEY_W'($urandom);
    end
    return k;
  endfunction

  // Read index: mostly inside the list, sometimes anywhere in 0..15.
  function automatic logic [3:0] pick_index();
    if (mirror.fill > 0 && $urandom_range(0, 3) != 0)
      return 4'($urandom_range(0, mirror.fill - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  // Mode mix by phase: 0 fills, 1 drains, 2 walks the cursor, 3 is mixed.
  function automatic logic [2:0] pick_mode(int phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 60) return MODE_INSERT;
        if (r < 70) return MODE_READ;
        if (r < 80) return MODE_ITER;
        if (r < 90) return MODE_REMOVE;
        if (r < 97) return MODE_POP;
      end
      1: begin
        if (r < 35) return MODE_POP;
        if (r < 70) return MODE_REMOVE;
        if (r < 80) return MODE_INSERT;
        if (r < 90) return MODE_ITER;
        if (r < 97) return MODE_READ;
      end
      2: begin
        if (r < 45) return MODE_ITER;
        if (r < 60) return MODE_REMOVE;
        if (r < 75) return MODE_INSERT;
        if (r < 88) return MODE_READ;
        if (r < 95) return MODE_POP;
      end
      default: begin
        if (r < 25) return MODE_INSERT;
        if (r < 40) return MODE_POP;
        if (r < 60) return MODE_REMOVE;
        if (r < 75) return MODE_READ;
        if (r < 92) return MODE_ITER;
      end
    endcase
    return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int          phase;
    bit          drained_once;

    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_INSERT;
    key_i       = '0;
    index_i     = '0;
    cycle_count = 0;
    burst_left  = next_burst();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list cases, no-op modes, both key extremes, equal keys,
    // reads in and out of range, a full walk with its end and rewind, and
    // removals below, above, absent, first, before and at the cursor.
    issue(MODE_ITER,     16'h0000, 4'd0);   // iterate on empty
    issue(MODE_POP,      16'h0000, 4'd0);   // pop on empty
    issue(MODE_REMOVE,   16'h1234, 4'd0);   // remove on empty
    issue(MODE_READ,     16'h0000, 4'd0);   // read on empty
    issue(MODE_SPARE_LO, 16'h5555, 4'd5);   // no-op mode
    issue(MODE_SPARE_HI, 16'hFFFF, 4'd15);  // no-op mode, all ones
    issue(MODE_INSERT,   16'hFFFF, 4'd0);
    issue(MODE_INSERT,   16'h0000, 4'd0);
    issue(MODE_INSERT,   16'h8000, 4'd0);
    issue(MODE_INSERT,   16'h8000, 4'd0);   // equal key goes after its twin
    issue(MODE_READ,     16'h0000, 4'd0);
    issue(MODE_READ,     16'h0000, 4'd3);
    issue(MODE_READ,     16'h0000, 4'd4);   // just past the end
    issue(MODE_READ,     16'h0000, 4'd15);
    issue(MODE_ITER,     16'h0000, 4'd0);
    issue(MODE_ITER,     16'h0000, 4'd0);
    issue(MODE_REMOVE,   16'h8000, 4'd0);   // before the cursor: cursor steps back
    issue(MODE_REMOVE,   16'h7FFF, 4'd0);   // inside range but absent
    issue(MODE_ITER,     16'h0000, 4'd0);
    issue(MODE_ITER,     16'h0000, 4'd0);   // last element: cursor ends
    issue(MODE_ITER,     16'h0000, 4'd0);   // end reported, rewinds
    issue(MODE_POP,      16'h0000, 4'd0);
    issue(MODE_REMOVE,   16'h0001, 4'd0);   // below the minimum
    issue(MODE_ITER,     16'h0000, 4'd0);
    issue(MODE_REMOVE,   16'hFFFF, 4'd0);   // at the cursor, nothing follows
    issue(MODE_ITER,     16'h0000, 4'd0);
    issue(MODE_REMOVE,   16'hFFFF, 4'd0);   // above the maximum
    issue(MODE_REMOVE,   16'h8000, 4'd0);   // first element: acts as a pop
    drain();

    // Random phases; the first boundary always waits out the pipeline.
    sent         = 0;
    drained_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      phase     = $urandom_range(0, 3);
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        issue(pick_mode(phase), pick_key(), pick_index());
        sent++;
      end
      if (!drained_once || $urandom_range(0, 1) == 0) begin
        drain();
        drained_once = 1'b1;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mirror.fail_count == 0 && mirror.pending_results.size() == 0) begin
      $display("PASS sorted_list_engine_unit");
    end else begin
      $display("FAIL sorted_list_engine_unit");
    end
    $finish;
  end

endmodule
